// File: hw/rtl/jse_pkg.sv
// Package for the JSON string escaper: command codes, character codes,
// escape sequence sizing and the hex digit helper. No dependencies.
package jse_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_START = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef logic [7:0] t_byte;

    // Longest escape sequence (\u00xx) and its index width
    localparam int unsigned SEQ_MAX   = 6;
    localparam int unsigned SEQ_IDX_W = $clog2(SEQ_MAX);

    typedef logic [SEQ_IDX_W-1:0] t_seq_idx;

    // Character codes
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_LOW_A  = 8'h61;
    localparam t_byte CH_LOW_N  = 8'h6E;
    localparam t_byte CH_LOW_R  = 8'h72;
    localparam t_byte CH_LOW_T  = 8'h74;
    localparam t_byte CH_LOW_U  = 8'h75;
    localparam t_byte CTRL_LIMIT = 8'd32;

    // Lowercase hex digit of a nibble
    function automatic t_byte hex_digit(input logic [3:0] nib);
        t_byte d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOW_A + {4'd0, nib - 4'd10};
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/jse_ifs.sv
// Valid/ready stream interfaces for the JSON string escaper: the input
// channel (command, char_byte) and the result channel (out_byte, run_last).
// Depends on nothing.
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_byte;

    modport source (output valid, output command, output char_byte, input ready);
    modport sink   (input valid, input command, input char_byte, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// File: hw/rtl/json_string_escaper.sv
// Top level of the JSON string escaper: decodes each item into its escape
// sequence and streams it out one byte per cycle while o_out is not stalled.
// Depends on jse_pkg and the interfaces in jse_ifs.sv.
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      command[1:0], char_byte[7:0]
//  o_out     out  valid/ready      out_byte[7:0], run_last
//  i_cfg_*   in   write enable     escape_slash_enable (1 bit)
//
// An item is decoded in the cycle it is accepted into the sequence register;
// its bytes leave through the result register one per cycle unless o_out
// stalls. An item escapes to 1 byte for plain bytes and quotes, 2 for short
// escapes and 6 for \u00xx. A new item is taken in the cycle the previous
// sequence hands over its last byte. Command 3 is taken and dropped. Stalls
// on o_out hold both registers. Reset is synchronous and clears control
// state and the slash enable.
module json_string_escaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);

    // Configuration register
    logic r_escape_slash;

    // Sequence register
    jse_pkg::t_byte    r_seq [jse_pkg::SEQ_MAX];
    jse_pkg::t_seq_idx r_len;
    jse_pkg::t_seq_idx r_idx;
    logic              r_busy;

    // Result register
    logic           r_out_valid;
    jse_pkg::t_byte r_out_byte;
    logic           r_out_last;

    jse_pkg::t_byte    n_seq [jse_pkg::SEQ_MAX];
    jse_pkg::t_seq_idx n_len;
    logic              n_has_out;

    logic in_fire;
    logic out_load;
    logic seq_last;
    jse_pkg::t_byte cb;

    assign cb       = i_in.char_byte;
    assign seq_last = (r_idx == r_len);
    assign out_load = r_busy && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_busy || (out_load && seq_last);
    assign in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

    // Decode the item into its escape sequence; r_len holds the last index
    always_comb begin
        for (int k = 0; k < jse_pkg::SEQ_MAX; k++) begin
            n_seq[k] = jse_pkg::CH_ZERO;
        end
        n_seq[0]  = jse_pkg::CH_BSLASH;
        n_len     = jse_pkg::t_seq_idx'(1);
        n_has_out = 1'b1;
        unique case (jse_pkg::t_cmd'(i_in.command))
            jse_pkg::CMD_START, jse_pkg::CMD_END: begin
                n_seq[0] = jse_pkg::CH_QUOTE;
                n_len    = '0;
            end
            jse_pkg::CMD_CHAR: begin
                if (cb == jse_pkg::CH_QUOTE || cb == jse_pkg::CH_BSLASH) begin
                    n_seq[1] = cb;
                end else if (cb == jse_pkg::CH_SLASH && r_escape_slash) begin
                    n_seq[1] = jse_pkg::CH_SLASH;
                end else if (cb == jse_pkg::CH_NL) begin
                    n_seq[1] = jse_pkg::CH_LOW_N;
                end else if (cb == jse_pkg::CH_CR) begin
                    n_seq[1] = jse_pkg::CH_LOW_R;
                end else if (cb == jse_pkg::CH_TAB) begin
                    n_seq[1] = jse_pkg::CH_LOW_T;
                end else if (cb < jse_pkg::CTRL_LIMIT) begin
                    n_seq[1] = jse_pkg::CH_LOW_U;
                    n_seq[4] = jse_pkg::hex_digit(cb[7:4]);
                    n_seq[5] = jse_pkg::hex_digit(cb[3:0]);
                    n_len    = jse_pkg::t_seq_idx'(jse_pkg::SEQ_MAX - 1);
                end else begin
                    n_seq[0] = cb;
                    n_len    = '0;
                end
            end
            default: begin
                // unused command: drop
                n_has_out = 1'b0;
            end
        endcase
    end

    // Hold the slash enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_slash <= 1'b0;
        end else if (i_cfg_we) begin
            r_escape_slash <= i_cfg_wdata;
        end
    end

    // Advance the sequence register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (in_fire) begin
            r_busy <= n_has_out;
            r_idx  <= '0;
        end else if (out_load) begin
            r_busy <= !seq_last;
            r_idx  <= r_idx + jse_pkg::t_seq_idx'(1);
        end
    end

    // Sequence payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_seq <= n_seq;
            r_len <= n_len;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_seq[r_idx];
            r_out_last <= seq_last;
        end
    end

endmodule

// File: tb/json_string_escaper_tb.sv
// Self-checking testbench for json_string_escaper: a directed table, then random quoted
// strings under random stalls, with every escaped byte predicted and checked in order.
// Depends on jse_pkg, the stream interfaces in jse_ifs.sv and the json_string_escaper RTL.
module json_string_escaper_tb;

    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 36;
    localparam int NUM_PHASES   = 6;
    localparam int PLAN_ROWS    = 25;

    // One byte of escaped text and its end-of-item flag
    typedef struct packed {
        jse_pkg::t_byte b;
        logic           last;
    } t_text_byte;

    // Directed row: a slash-enable write (cfg) or an item, with optional typed-in text
    typedef struct packed {
        logic           cfg;
        jse_pkg::t_cmd  cmd;
        jse_pkg::t_byte c;
        logic           typed;
        logic [2:0]     n;
        logic [47:0]    want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    jse_in_if  in_ch ();
    jse_out_if out_ch ();

    json_string_escaper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_text_byte  expected_text [$];
    t_text_byte  head_byte;
    logic        slash_on;
    int          errors;
    int          idle_cycles;
    logic        src_gaps;
    logic        sink_stalls;
    int          stall_left;
    logic        row_typed;
    int          row_n;
    logic [47:0] row_want;

    t_dir_row plan [PLAN_ROWS] = '{
        '{1'b0, jse_pkg::CMD_START, 8'h00, 1'b1, 3'd1, "\""},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h00, 1'b1, 3'd6, "\\u0000"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h1F, 1'b1, 3'd6, "\\u001f"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h0A, 1'b1, 3'd2, "\\n"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h0D, 1'b1, 3'd2, "\\r"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h09, 1'b1, 3'd2, "\\t"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h22, 1'b1, 3'd2, "\\\""},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h5C, 1'b1, 3'd2, "\\\\"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h2F, 1'b1, 3'd1, "/"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h7F, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h80, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'hFF, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h20, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h7E, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h1B, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h08, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_NONE,  8'h55, 1'b1, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_NONE,  8'hFF, 1'b1, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_END,   8'hAA, 1'b1, 3'd1, "\""},
        '{1'b1, jse_pkg::CMD_CHAR,  8'h01, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_START, 8'hFF, 1'b1, 3'd1, "\""},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h2F, 1'b1, 3'd2, "\\/"},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h2E, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_CHAR,  8'h01, 1'b0, 3'd0, 48'd0},
        '{1'b0, jse_pkg::CMD_END,   8'h00, 1'b1, 3'd1, "\""}
    };

    // Lowercase hex digit of a nibble
    function automatic jse_pkg::t_byte hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h57 + {4'd0, nib};
    endfunction

    // Append the escaped text of one item to the expected stream
    function automatic void predict_escape(input jse_pkg::t_cmd cmd, input jse_pkg::t_byte c);
        jse_pkg::t_byte seq [6];
        int             n;
        n = 2;
        seq[0] = jse_pkg::CH_BSLASH;
        case (cmd)
            jse_pkg::CMD_START, jse_pkg::CMD_END: begin
                seq[0] = jse_pkg::CH_QUOTE;
                n = 1;
            end
            jse_pkg::CMD_CHAR: begin
                if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
                    seq[1] = c;
                end else if (c == jse_pkg::CH_SLASH && slash_on) begin
                    seq[1] = jse_pkg::CH_SLASH;
                end else if (c == jse_pkg::CH_NL) begin
                    seq[1] = "n";
                end else if (c == jse_pkg::CH_CR) begin
                    seq[1] = "r";
                end else if (c == jse_pkg::CH_TAB) begin
                    seq[1] = "t";
                end else if (c < jse_pkg::CTRL_LIMIT) begin
                    seq[1] = "u";
                    seq[2] = "0";
                    seq[3] = "0";
                    seq[4] = hex_char(c[7:4]);
                    seq[5] = hex_char(c[3:0]);
                    n = 6;
                end else begin
                    seq[0] = c;
                    n = 1;
                end
            end
            default: begin
                n = 0;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            expected_text.push_back('{seq[k], k == n - 1});
        end
    endfunction

    // Offer one item at the falling edge, after an optional gap, and hold it until taken
    task automatic send_item(input jse_pkg::t_cmd cmd, input jse_pkg::t_byte c,
                             input logic typed, input int n, input logic [47:0] want);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.char_byte <= c;
        row_typed       <= typed;
        row_n           <= n;
        row_want        <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Drain the block, then write the slash enable while it is idle
    task automatic write_slash(input logic en);
        in_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        slash_on = en;
    endtask

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result side in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Predict on each accepted item, check each accepted byte, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (row_typed) begin
                for (int k = 0; k < row_n; k++) begin
                    expected_text.push_back('{row_want[8 * (row_n - 1 - k) +: 8],
                                              k == row_n - 1});
                end
            end else begin
                predict_escape(jse_pkg::t_cmd'(in_ch.command), in_ch.char_byte);
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_text.size() == 0) begin
                errors++;
                $display("%0t: expected no byte, actual out_byte %h run_last %b",
                         $time, out_ch.out_byte, out_ch.run_last);
            end else begin
                head_byte = expected_text.pop_front();
                if (out_ch.out_byte !== head_byte.b) begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, head_byte.b, out_ch.out_byte);
                end
                if (out_ch.run_last !== head_byte.last) begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b",
                             $time, head_byte.last, out_ch.run_last);
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("json_string_escaper test failed");
            $finish;
        end
    end

    initial begin
        int             len;
        int             sent;
        jse_pkg::t_cmd  cmd;
        jse_pkg::t_byte ch;
        in_ch.valid     = 1'b0;
        in_ch.command   = jse_pkg::CMD_CHAR;
        in_ch.char_byte = 8'h00;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        i_rst_n         = 1'b0;
        slash_on        = 1'b0;
        errors          = 0;
        idle_cycles     = 0;
        src_gaps        = 1'b1;
        sink_stalls     = 1'b1;
        stall_left      = 0;
        row_typed       = 1'b0;
        row_n           = 0;
        row_want        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            if (plan[r].cfg) begin
                write_slash(plan[r].c[0]);
            end else begin
                send_item(plan[r].cmd, plan[r].c, plan[r].typed, int'(plan[r].n),
                          plan[r].want);
            end
        end

        // Random strings, alternating the slash enable; phases 3 and 5 run without gaps or stalls
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slash(~p[0]);
            src_gaps    = (p == 0 || p == 1 || p == 4);
            sink_stalls = (p == 0 || p == 2 || p == 4);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any command with any byte
                    cmd = jse_pkg::t_cmd'($urandom_range(0, 3));
                    send_item(cmd, jse_pkg::t_byte'($urandom_range(0, 255)), 1'b0, 0, '0);
                    if (cmd != jse_pkg::CMD_NONE) sent++;
                end else begin
                    send_item(jse_pkg::CMD_START, jse_pkg::t_byte'($urandom_range(0, 255)),
                              1'b0, 0, '0);
                    sent++;
                    len = $urandom_range(0, 10);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 7))
                            0: ch = jse_pkg::CH_QUOTE;
                            1: ch = jse_pkg::CH_BSLASH;
                            2: ch = jse_pkg::CH_SLASH;
                            3: ch = jse_pkg::t_byte'($urandom_range(0, 31));
                            4: ch = jse_pkg::t_byte'($urandom_range(128, 255));
                            5: ch = ($urandom_range(0, 1) == 0) ? jse_pkg::CH_NL :
                                    ($urandom_range(0, 1) == 0) ? jse_pkg::CH_CR :
                                    jse_pkg::CH_TAB;
                            default: ch = jse_pkg::t_byte'($urandom_range(0, 255));
                        endcase
                        send_item(jse_pkg::CMD_CHAR, ch, 1'b0, 0, '0);
                        sent++;
                    end
                    // Leave some strings unterminated
                    if ($urandom_range(0, 7) != 0) begin
                        send_item(jse_pkg::CMD_END, jse_pkg::t_byte'($urandom_range(0, 255)),
                                  1'b0, 0, '0);
                        sent++;
                    end
                end
            end
        end

        // Drop valid, drain the results and let the block settle
        in_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("json_string_escaper test passed");
        end else begin
            $display("json_string_escaper test failed");
        end
        $finish;
    end

endmodule
